// File: design/ctbm_pkg.sv
// Shared types and constants for the capture triple-buffer manager.
package ctbm_pkg;

    localparam int BUFFER_COUNT       = 3;
    localparam int SAMPLES_PER_BUFFER = 1024;
    localparam int US_PER_SECOND      = 1000000;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 2;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int RATE_W  = 32;

    // Rate numerator; the largest buffer size still fits 32 bits, so the
    // quotient never needs saturation.
    localparam logic [RATE_W-1:0] RATE_NUM =
        RATE_W'(64'(SAMPLES_PER_BUFFER) * 64'(US_PER_SECOND));
    localparam int DIV_STEPS = RATE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_FILL    = 3'd0,
        KIND_ACQUIRE = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_START   = 3'd3,
        KIND_STOP    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_FILL,
        OP_ACQUIRE,
        OP_RELEASE,
        OP_START,
        OP_STOP
    } op_t;

    typedef enum logic [1:0] {
        MARK_EMPTY      = 2'd0,
        MARK_FILLING    = 2'd1,
        MARK_FULL       = 2'd2,
        MARK_PROCESSING = 2'd3
    } mark_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } bstate_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] time_us;
        logic [IDX_W-1:0]  rel_index;
        logic              rel_ok;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [IDX_W-1:0]   index;
        logic [TIME_W-1:0]  stamp;
        logic               overrun;
        logic [COUNT_W-1:0] count;
        logic [RATE_W-1:0]  rate;
        logic               running;
    } result_t;

endpackage

// File: design/ctbm_front.sv
// Front end: accepts requests, decodes them and queues them for the back end.
module ctbm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ctbm_pkg::KIND_W-1:0]   kind,
    input  logic [ctbm_pkg::TIME_W-1:0]   time_ms,
    input  logic [ctbm_pkg::TIME_W-1:0]   time_us,
    input  logic [ctbm_pkg::IDX_W-1:0]    release_index,
    output ctbm_pkg::cmd_t                cmd,
    output logic                          cmd_valid,
    input  logic                          cmd_pop
);
    import ctbm_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              dec;
    logic              do_push;
    logic              do_pop;

    // request decode
    always_comb
    begin
        dec.time_ms   = time_ms;
        dec.time_us   = time_us;
        dec.rel_index = release_index;
        dec.rel_ok    = (release_index < IDX_W'(BUFFER_COUNT));
        unique case (kind_t'(kind))
            KIND_FILL:    dec.op = OP_FILL;
            KIND_ACQUIRE: dec.op = OP_ACQUIRE;
            KIND_RELEASE: dec.op = OP_RELEASE;
            KIND_START:   dec.op = OP_START;
            KIND_STOP:    dec.op = OP_STOP;
            default:      dec.op = OP_NOP;
        endcase
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: design/ctbm_back.sv
// Back end: buffer ring state, serial rate divider and result register.
module ctbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ctbm_pkg::cmd_t    cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output ctbm_pkg::result_t res
);
    import ctbm_pkg::*;

    bstate_t             state_reg, state_next;
    mark_t               mark_reg  [BUFFER_COUNT];
    mark_t               mark_next [BUFFER_COUNT];
    logic [TIME_W-1:0]   stamp_reg  [BUFFER_COUNT];
    logic [TIME_W-1:0]   stamp_next [BUFFER_COUNT];
    logic [IDX_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    latest_reg, latest_next;
    logic                capture_reg, capture_next;
    logic [TIME_W-1:0]   prev_us_reg, prev_us_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [COUNT_W-1:0]  drop_reg, drop_next;
    logic [TIME_W-1:0]   dt_reg, dt_next;
    logic [RATE_W-1:0]   rem_reg, rem_next;
    logic [RATE_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;

    logic [IDX_W-1:0]    cur;
    logic [IDX_W-1:0]    nxt;
    logic [TIME_W-1:0]   dt;
    logic [RATE_W:0]     trial;
    logic                acquired;

    assign empty = !out_valid_reg;
    assign res   = res_reg;

    always_comb
    begin
        mark_next       = mark_reg;
        stamp_next      = stamp_reg;
        fill_next       = fill_reg;
        latest_next     = latest_reg;
        capture_next    = capture_reg;
        prev_us_next    = prev_us_reg;
        prev_valid_next = prev_valid_reg;
        rate_next       = rate_reg;
        drop_next       = drop_reg;
        dt_next         = dt_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !pop;
        res_next        = res_reg;
        state_next      = state_reg;
        cmd_pop         = 1'b0;
        cur             = fill_reg;
        nxt             = '0;
        acquired        = 1'b0;
        dt              = cmd.time_us - prev_us_reg;
        trial           = {rem_reg, quo_reg[RATE_W-1]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || pop))
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    res_next.ok      = 1'b0;
                    res_next.stamp   = '0;
                    res_next.overrun = 1'b0;
                    unique case (cmd.op)
                        OP_FILL:
                        begin
                            cur                  = fill_reg;
                            mark_next[cur]       = MARK_FULL;
                            stamp_next[cur]      = cmd.time_ms;
                            latest_next          = cur;
                            if (capture_reg)
                            begin
                                nxt = (cur == IDX_W'(BUFFER_COUNT - 1)) ? '0 : cur + 1'b1;
                                if (mark_reg[nxt] == MARK_PROCESSING)
                                begin
                                    nxt              = cur;
                                    drop_next        = drop_reg + 1'b1;
                                    res_next.overrun = 1'b1;
                                end
                                fill_next      = nxt;
                                mark_next[nxt] = MARK_FILLING;
                            end
                            prev_us_next    = cmd.time_us;
                            prev_valid_next = 1'b1;
                            // interval known and nonzero: hold result for the divide
                            if (prev_valid_reg && (dt != '0))
                            begin
                                dt_next        = dt;
                                rem_next       = '0;
                                quo_next       = RATE_NUM;
                                step_next      = STEP_W'(DIV_STEPS - 1);
                                out_valid_next = 1'b0;
                                state_next     = ST_DIV;
                            end
                        end
                        OP_ACQUIRE:
                        begin
                            cur = latest_reg;
                            if (mark_reg[cur] == MARK_FULL)
                            begin
                                mark_next[cur] = MARK_PROCESSING;
                                res_next.ok    = 1'b1;
                                res_next.stamp = stamp_reg[cur];
                                acquired       = 1'b1;
                            end
                        end
                        OP_RELEASE:
                        begin
                            for (int i = 0; i < BUFFER_COUNT; i++)
                            begin
                                if (cmd.rel_ok && (cmd.rel_index == IDX_W'(i)) &&
                                    (mark_reg[i] == MARK_PROCESSING))
                                begin
                                    mark_next[i] = MARK_EMPTY;
                                end
                            end
                        end
                        OP_START:
                        begin
                            capture_next = 1'b1;
                            fill_next    = '0;
                            mark_next[0] = MARK_FILLING;
                        end
                        OP_STOP:
                        begin
                            if (capture_reg)
                            begin
                                capture_next = 1'b0;
                                for (int i = 0; i < BUFFER_COUNT; i++)
                                begin
                                    mark_next[i]  = MARK_EMPTY;
                                    stamp_next[i] = '0;
                                end
                                fill_next   = '0;
                                latest_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.index   = acquired ? cur : fill_next;
                    res_next.count   = drop_next;
                    res_next.rate    = rate_next;
                    res_next.running = capture_next;
                end
            end
            ST_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                if (trial >= {1'b0, dt_reg})
                begin
                    rem_next = RATE_W'(trial - {1'b0, dt_reg});
                    quo_next = {quo_reg[RATE_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[RATE_W-1:0];
                    quo_next = {quo_reg[RATE_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    rate_next      = quo_next;
                    res_next.rate  = quo_next;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < BUFFER_COUNT; i++)
            begin
                mark_reg[i]  <= MARK_EMPTY;
                stamp_reg[i] <= '0;
            end
            fill_reg       <= '0;
            latest_reg     <= '0;
            capture_reg    <= 1'b0;
            prev_us_reg    <= '0;
            prev_valid_reg <= 1'b0;
            rate_reg       <= '0;
            drop_reg       <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            mark_reg       <= mark_next;
            stamp_reg      <= stamp_next;
            fill_reg       <= fill_next;
            latest_reg     <= latest_next;
            capture_reg    <= capture_next;
            prev_us_reg    <= prev_us_next;
            prev_valid_reg <= prev_valid_next;
            rate_reg       <= rate_next;
            drop_reg       <= drop_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg  <= dt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

endmodule

// File: design/capture_triple_buffer_manager_top.sv
// Top level of the capture triple-buffer manager.
//
// Keeps a ring of three capture buffers (empty, filling, full, processing)
// and serves fill-complete, acquire, release, start and stop requests, one
// result per request, in order. Requests enter through a push/full port into
// a two-entry request queue. Results leave through an empty/pop port from a
// one-entry result register. While a result waits, the back end holds, and
// intake stops once the queue holds two requests. Every request is finished
// in the idle state of the back end, except a fill completion that has an
// earlier completion and a nonzero microsecond interval. That completion also
// runs the sample rate divide (1024 * 1000000 / interval) in a restoring
// divider that produces one quotient bit per cycle. The divider
// is the only multi-cycle unit and sets the worst-case rate. The quotient can
// never exceed 32 bits, so the rate output needs no clamp. No clearing pass
// follows reset: the block takes requests as soon as reset is released.
module capture_triple_buffer_manager_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [ctbm_pkg::KIND_W-1:0]    kind,
    input  logic [ctbm_pkg::TIME_W-1:0]    time_ms,
    input  logic [ctbm_pkg::TIME_W-1:0]    time_us,
    input  logic [ctbm_pkg::IDX_W-1:0]     release_index,
    output logic                           empty,
    input  logic                           pop,
    output logic                           ok,
    output logic [ctbm_pkg::IDX_W-1:0]     buffer_index,
    output logic [ctbm_pkg::TIME_W-1:0]    timestamp_ms,
    output logic                           overrun,
    output logic [ctbm_pkg::COUNT_W-1:0]   overrun_count,
    output logic [ctbm_pkg::RATE_W-1:0]    measured_rate_hz,
    output logic                           running
);
    import ctbm_pkg::*;

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t res;

    // decode and queue incoming requests
    ctbm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .kind          (kind),
        .time_ms       (time_ms),
        .time_us       (time_us),
        .release_index (release_index),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop)
    );

    // ring bookkeeping, rate divider, result register
    ctbm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign ok               = res.ok;
    assign buffer_index     = res.index;
    assign timestamp_ms     = res.stamp;
    assign overrun          = res.overrun;
    assign overrun_count    = res.count;
    assign measured_rate_hz = res.rate;
    assign running          = res.running;

endmodule

// File: design/ctbm_checker.sv
// Port-level checks for the capture triple-buffer manager, bound to the top.
module ctbm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic                           ok,
    input logic [ctbm_pkg::IDX_W-1:0]     buffer_index,
    input logic [ctbm_pkg::TIME_W-1:0]    timestamp_ms,
    input logic                           overrun,
    input logic [ctbm_pkg::COUNT_W-1:0]   overrun_count,
    input logic                           running
);
    import ctbm_pkg::*;

    // acquire and completion results never both flag
    a_ok_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(ok && overrun))
        else $error("ok and overrun both set");

    // stamp is only shown for a successful acquire
    a_stamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !ok) |-> (timestamp_ms == '0))
        else $error("nonzero stamp without acquire");

    // an overrun only happens while capture runs
    a_overrun_running: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overrun) |-> running)
        else $error("overrun while stopped");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(overrun_count) && $stable(buffer_index)))
        else $error("result changed while stalled");

    // buffer index stays inside the ring
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (buffer_index < IDX_W'(BUFFER_COUNT)))
        else $error("buffer index out of range");

endmodule

bind capture_triple_buffer_manager_top ctbm_checker u_ctbm_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the capture triple-buffer manager top level.
module testbench;
    import ctbm_pkg::*;

    // Run shape
    localparam int RANDOM_REQUESTS = 800;
    localparam int DRAIN_AT        = 400;   // random request that waits for all results
    localparam int HOLD_AT_RESULT  = 300;   // result count that starts the long pop hold
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_EPOCH     = 64;    // cycles per receiver stall mode
    localparam int TAIL_CYCLES     = 40;    // longer than one divide plus queue slack
    localparam int IDLE_LIMIT      = 4000;  // cycles with no handshake at all

    // Kind codes the block does not know; they must produce a plain status result.
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = KIND_W'(KIND_STOP) + 1'b1;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = '1;
    localparam logic [IDX_W-1:0]  INDEX_OFF_RING = '1;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_QUARTER,
        STALL_TOGGLE
    } stall_mode_t;

    // One request as the sender sees it; drain holds it back until all results are in.
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] ms;
        logic [TIME_W-1:0] us;
        logic [IDX_W-1:0]  rel;
        bit                drain;
    } request_t;

    // One status word as the block reports it.
    typedef struct {
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [TIME_W-1:0]  stamp;
        logic               overrun;
        logic [COUNT_W-1:0] drops;
        logic [RATE_W-1:0]  rate;
        logic               run;
    } status_t;

    // DUT ports; every input is known from time zero.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [KIND_W-1:0]   kind = '0;
    logic [TIME_W-1:0]   time_ms = '0;
    logic [TIME_W-1:0]   time_us = '0;
    logic [IDX_W-1:0]    release_index = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic                ok;
    logic [IDX_W-1:0]    buffer_index;
    logic [TIME_W-1:0]   timestamp_ms;
    logic                overrun;
    logic [COUNT_W-1:0]  overrun_count;
    logic [RATE_W-1:0]   measured_rate_hz;
    logic                running;

    capture_triple_buffer_manager_top u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Ring predictor: its own copy of the buffer marks, stamps, indexes,
    // rate and drop counter, stepped once per accepted request.
    // ------------------------------------------------------------------
    mark_t              ring_mark [BUFFER_COUNT];
    logic [TIME_W-1:0]  ring_stamp [BUFFER_COUNT];
    int unsigned        fill_at;
    int unsigned        latest_at;
    bit                 capturing;
    logic [TIME_W-1:0]  last_us;
    bit                 have_last_us;
    logic [RATE_W-1:0]  rate_hz;
    logic [COUNT_W-1:0] drops;

    // Coverage tallies for the closing summary
    int fills_seen, overruns_seen, handouts_seen;
    logic [RATE_W-1:0] peak_rate;

    request_t request_backlog[$];   // requests not yet taken by the block
    status_t  status_due[$];        // predicted status words, oldest first
    int       total_requests;
    int       requests_taken = 0;   // written with NBA only: stable at the edge
    int       results_taken = 0;
    int       mismatches = 0;

    function automatic void clear_ring();
        for (int i = 0; i < BUFFER_COUNT; i++)
        begin
            ring_mark[i]  = MARK_EMPTY;
            ring_stamp[i] = '0;
        end
        fill_at   = 0;
        latest_at = 0;
    endfunction

    function automatic status_t advance_ring(request_t r);
        status_t           s;
        int unsigned       cur;
        int unsigned       nxt;
        logic [TIME_W-1:0] span;
        logic [63:0]       quot;
        s = '{default: '0};
        case (r.kind)
            KIND_FILL:
            begin
                // Completion marks the buffer full even while stopped.
                cur = (fill_at < BUFFER_COUNT) ? fill_at : 0;
                ring_mark[cur]  = MARK_FULL;
                ring_stamp[cur] = r.ms;
                latest_at       = cur;
                if (capturing)
                begin
                    nxt = (cur + 1) % BUFFER_COUNT;
                    // Next buffer still with the consumer: drop this frame.
                    if (ring_mark[nxt] == MARK_PROCESSING)
                    begin
                        nxt       = cur;
                        drops     = drops + 1'b1;
                        s.overrun = 1'b1;
                        overruns_seen++;
                    end
                    fill_at       = nxt;
                    ring_mark[nxt] = MARK_FILLING;
                end
                // Rate only from a real, nonzero interval.
                if (have_last_us)
                begin
                    span = r.us - last_us;
                    if (span != '0)
                    begin
                        quot = (64'(SAMPLES_PER_BUFFER) * 64'(US_PER_SECOND)) / 64'(span);
                        rate_hz = (quot > 64'hFFFF_FFFF) ? '1 : quot[RATE_W-1:0];
                    end
                end
                last_us      = r.us;
                have_last_us = 1'b1;
                if (rate_hz > peak_rate)
                    peak_rate = rate_hz;
                fills_seen++;
            end
            KIND_ACQUIRE:
            begin
                cur = (latest_at < BUFFER_COUNT) ? latest_at : 0;
                if (ring_mark[cur] == MARK_FULL)
                begin
                    ring_mark[cur] = MARK_PROCESSING;
                    s.ok    = 1'b1;
                    s.stamp = ring_stamp[cur];
                    s.idx   = IDX_W'(cur);
                    handouts_seen++;
                end
            end
            KIND_RELEASE:
            begin
                if (r.rel < BUFFER_COUNT && ring_mark[r.rel] == MARK_PROCESSING)
                    ring_mark[r.rel] = MARK_EMPTY;
            end
            KIND_START:
            begin
                capturing    = 1'b1;
                fill_at      = 0;
                ring_mark[0] = MARK_FILLING;
            end
            KIND_STOP:
            begin
                if (capturing)
                begin
                    capturing = 1'b0;
                    clear_ring();
                end
            end
            default: ;
        endcase
        if (!s.ok)
            s.idx = IDX_W'(fill_at);
        s.drops = drops;
        s.rate  = rate_hz;
        s.run   = capturing;
        return s;
    endfunction

    function automatic void queue_request(logic [KIND_W-1:0] k, logic [TIME_W-1:0] ms,
                                          logic [TIME_W-1:0] us, logic [IDX_W-1:0] rel,
                                          bit drain = 1'b0);
        request_t r;
        r = '{k, ms, us, rel, drain};
        request_backlog.push_back(r);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // A request stays on the port until the block takes it. Prediction
    // happens at the edge where the request is taken.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        request_t sent;
        bit       taken;
        int       outstanding;
        if (!rst_n)
        begin
            push       <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                sent = '{kind, time_ms, time_us, release_index, 1'b0};
                status_due.push_back(advance_ring(sent));
                void'(request_backlog.pop_front());
                requests_taken <= requests_taken + 1;
            end
            // results_taken is the pre-edge count, so this is race free.
            outstanding = requests_taken + int'(taken) - results_taken;
            if (taken || !push)
            begin
                if (request_backlog.size() == 0 || gap_left > 0 ||
                    (request_backlog[0].drain && outstanding != 0))
                begin
                    push <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    push          <= 1'b1;
                    kind          <= request_backlog[0].kind;
                    time_ms       <= request_backlog[0].ms;
                    time_us       <= request_backlog[0].us;
                    release_index <= request_backlog[0].rel;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        // Some long bursts with no gap at all between them.
                        burst_left = $urandom_range(1, ($urandom_range(3) == 0) ? 60 : 12);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and pop pattern. The stall mode changes every epoch;
    // once, a long hold keeps pop low so the request queue backs up and
    // full is seen by the driver.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode;
    int          stall_tick;
    int          hold_left;
    bit          hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_mode = STALL_NONE;
            stall_tick = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (status_due.size() == 0)
                begin
                    $error("status word popped with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    check_field("ok", 32'(want.ok), 32'(ok));
                    check_field("buffer_index", 32'(want.idx), 32'(buffer_index));
                    check_field("timestamp_ms", want.stamp, timestamp_ms);
                    check_field("overrun", 32'(want.overrun), 32'(overrun));
                    check_field("overrun_count", want.drops, overrun_count);
                    check_field("measured_rate_hz", want.rate, measured_rate_hz);
                    check_field("running", 32'(want.run), 32'(running));
                end
                results_taken <= results_taken + 1;
            end

            if (stall_tick == 0)
                stall_mode = stall_mode_t'($urandom_range(3));
            stall_tick = (stall_tick + 1) % STALL_EPOCH;

            if (!hold_done && results_taken >= HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:    pop <= 1'b1;
                    STALL_HALF:    pop <= 1'($urandom_range(1));
                    STALL_QUARTER: pop <= ($urandom_range(3) == 0);
                    default:       pop <= ~pop;
                endcase
            end
        end
    end

    // Watchdog: no request and no result taken for too long ends the run.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int                pick;
        logic [TIME_W-1:0] us_now;
        logic [TIME_W-1:0] ms_now;
        logic [KIND_W-1:0] k;
        logic [IDX_W-1:0]  rel;

        clear_ring();
        capturing     = 1'b0;
        last_us       = '0;
        have_last_us  = 1'b0;
        rate_hz       = '0;
        drops         = '0;
        peak_rate     = '0;
        fills_seen    = 0;
        overruns_seen = 0;
        handouts_seen = 0;

        // Directed: walk the ring through every special case once.
        queue_request(KIND_UNUSED_LO, $urandom, $urandom, IDX_W'($urandom));  // unknown kind
        queue_request(KIND_ACQUIRE, '0, '0, '0);         // nothing full yet
        queue_request(KIND_FILL, '1, '0, '0);            // stopped, first completion
        queue_request(KIND_ACQUIRE, '0, '0, '0);         // hands out buffer 0
        queue_request(KIND_RELEASE, '0, '0, INDEX_OFF_RING);  // off the ring
        queue_request(KIND_RELEASE, '0, '0, '0);         // frees buffer 0
        queue_request(KIND_STOP, '0, '0, '0);            // stop while stopped
        queue_request(KIND_START, '0, '0, '0);
        queue_request(KIND_FILL, '0, '0, '0);            // zero interval keeps rate
        queue_request(KIND_FILL, 32'd1, 32'd1, '0);      // one-microsecond interval
        queue_request(KIND_ACQUIRE, '0, '0, '0);         // buffer 1 to the consumer
        queue_request(KIND_RELEASE, '0, '0, IDX_W'(2));  // buffer 2 not processing
        queue_request(KIND_FILL, 32'd2, '1, '0);         // interval near the 32-bit maximum
        queue_request(KIND_FILL, 32'd3, '0, '0);         // next busy: overrun
        queue_request(KIND_ACQUIRE, '0, '0, '0);         // reused buffer not acquirable
        queue_request(KIND_FILL, 32'd4, 32'd1000, '0);   // second overrun
        queue_request(KIND_RELEASE, '0, '0, IDX_W'(1));
        queue_request(KIND_START, '0, '0, '0);           // restart while running
        queue_request(KIND_ACQUIRE, '0, '0, '0);
        queue_request(KIND_FILL, '1, 32'd2000, '0, 1'b1);
        queue_request(KIND_STOP, '0, '0, '0);            // stop while running
        queue_request(KIND_UNUSED_HI, '1, '1, '1);
        queue_request(KIND_FILL, 32'h8000_0000, 32'h8000_0000, '0);
        queue_request(KIND_ACQUIRE, '0, '0, '0);

        // Random: mostly running sessions with time moving forward, so the
        // ring keeps cycling through overruns, handouts and releases.
        us_now = $urandom;
        ms_now = $urandom;
        queue_request(KIND_START, $urandom, $urandom, IDX_W'($urandom));
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 48)       k = KIND_FILL;
            else if (pick < 73)  k = KIND_ACQUIRE;
            else if (pick < 93)  k = KIND_RELEASE;
            else if (pick < 95)  k = KIND_START;
            else if (pick < 97)  k = KIND_STOP;
            else                 k = KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));

            pick = $urandom_range(99);
            if (pick < 5)        us_now = us_now;
            else if (pick < 15)  us_now = us_now + $urandom_range(1, 50);
            else if (pick < 85)  us_now = us_now + $urandom_range(1000, 30000);
            else                 us_now = $urandom;
            ms_now = ($urandom_range(9) == 0) ? $urandom : ms_now + $urandom_range(1, 40);
            rel    = ($urandom_range(9) == 0) ? INDEX_OFF_RING : IDX_W'($urandom_range(2));

            if (k == KIND_FILL)
                queue_request(k, ms_now, us_now, IDX_W'($urandom), i == DRAIN_AT);
            else
                queue_request(k, $urandom, $urandom, rel, i == DRAIN_AT);
        end
        total_requests = request_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (requests_taken != total_requests || results_taken != requests_taken);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (status_due.size() != 0)
        begin
            $error("%0d status words never arrived", status_due.size());
            mismatches++;
        end

        $display("Checked %0d status words: %0d completions, %0d dropped frames, %0d handouts.",
                 results_taken, fills_seen, overruns_seen, handouts_seen);
        $display("Peak rate %0d Hz; long pop hold and full-drain pause both exercised.",
                 peak_rate);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
